// File: hdl/afk_pkg.sv
// Package: types, constants and tables for the arm forward kinematics core.
package afk_pkg;

  localparam int NumJoints   = 6;
  localparam int CordicSteps = 14;
  localparam int CordicX0    = 9949;
  localparam int PiU16       = 205887;
  localparam int HalfPiU16   = 102944;
  localparam int OneQ14      = 16384;

  localparam logic [1:0] REG_UPPER_ARM   = 2'd0;
  localparam logic [1:0] REG_FOREARM     = 2'd1;
  localparam logic [1:0] REG_ELBOW_NEAR  = 2'd2;
  localparam logic [1:0] REG_ELBOW_FAR   = 2'd3;

  typedef logic signed [47:0] acc_t;
  typedef logic signed [39:0] pos_t;
  typedef logic signed [19:0] rot_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_MAC,
    ST_STORE,
    ST_NEXT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       start;
    logic [2:0] idx;
  } cordic_ctl_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic signed [19:0] sin_v;
    logic signed [19:0] cos_v;
  } cordic_sts_t;

  function automatic logic [17:0] atan_lut(input logic [3:0] i);
    case (i)
      4'd0:  atan_lut = 18'd51472;
      4'd1:  atan_lut = 18'd30386;
      4'd2:  atan_lut = 18'd16055;
      4'd3:  atan_lut = 18'd8150;
      4'd4:  atan_lut = 18'd4091;
      4'd5:  atan_lut = 18'd2047;
      4'd6:  atan_lut = 18'd1024;
      4'd7:  atan_lut = 18'd512;
      4'd8:  atan_lut = 18'd256;
      4'd9:  atan_lut = 18'd128;
      4'd10: atan_lut = 18'd64;
      4'd11: atan_lut = 18'd32;
      4'd12: atan_lut = 18'd16;
      4'd13: atan_lut = 18'd8;
      default: atan_lut = 18'd0;
    endcase
  endfunction

  // twist: 0 none, 1 plus 90, 2 minus 90
  function automatic logic [1:0] twist_lut(input logic [2:0] j);
    case (j)
      3'd0: twist_lut = 2'd0;
      3'd4: twist_lut = 2'd2;
      default: twist_lut = 2'd1;
    endcase
  endfunction

  function automatic logic off90_lut(input logic [2:0] j);
    case (j)
      3'd1, 3'd2, 3'd4: off90_lut = 1'b1;
      default: off90_lut = 1'b0;
    endcase
  endfunction

  function automatic acc_t round_q14(input acc_t v);
    acc_t t;
    if (v >= 0) begin
      t = (v + 48'sd8192) >>> 14;
    end else begin
      t = -((-v + 48'sd8192) >>> 14);
    end
    return t;
  endfunction

endpackage

// File: hdl/afk_if.sv
// Valid/ready channel interfaces for the arm forward kinematics core.
interface afk_in_if (input logic clk);
  logic               valid;
  logic               ready;
  logic signed [15:0] joint_angle_0;
  logic signed [15:0] joint_angle_1;
  logic signed [15:0] joint_angle_2;
  logic signed [15:0] joint_angle_3;
  logic signed [15:0] joint_angle_4;
  logic signed [15:0] joint_angle_5;
  logic [2:0]         joint_count;
  modport source (input clk, ready, output valid, joint_angle_0, joint_angle_1,
                  joint_angle_2, joint_angle_3, joint_angle_4, joint_angle_5,
                  joint_count);
  modport sink (input clk, valid, joint_angle_0, joint_angle_1, joint_angle_2,
                joint_angle_3, joint_angle_4, joint_angle_5, joint_count,
                output ready);
endinterface

interface afk_out_if (input logic clk);
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  modport source (input clk, ready, output valid, pos_x, pos_y, pos_z);
  modport sink (input clk, valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface afk_cfg_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [13:0] data;
  modport source (input clk, ready, output valid, index, data);
  modport sink (input clk, valid, index, data, output ready);
endinterface

// File: hdl/arm_forward_kinematics_core.sv
// Top level of the arm forward kinematics core.
// Usage: write link registers on cfg (index 0..3) while idle; reset loads
// defaults 7457, 6899, 722, 558 and clears the output valid. Send one transaction
// on in_ch with six Q3.13 joint angles and a joint count (values above six
// act as six). The core drops ready while it works, then presents pos_x/y/z
// on out_ch and holds them until the receiver takes them; ready on in_ch
// returns the cycle after.
// Each joint takes a sequencing state, a pass through the CORDIC unit and work
// on the single shared multiplier: 12 dot products of three terms, each
// accumulated and then written back in a store state. One transaction at a
// time; a stalled receiver holds the result and no new transaction is taken.
module arm_forward_kinematics_core (
  input logic   clk,
  input logic   rst,
  afk_in_if.sink   in_ch,
  afk_out_if.source out_ch,
  afk_cfg_if.sink  cfg
);
  afk_pkg::state_t state, state_next;

  logic [13:0] upper_arm, forearm, elb_near, elb_far;
  logic signed [15:0] ang [6];
  logic [2:0] count;
  logic [2:0] jnt;
  logic signed [19:0] rm [9];
  logic signed [39:0] pv [3];
  logic signed [19:0] sn, cs;
  logic [1:0] r_i, k_i, m_i;
  logic       out_valid;
  logic signed [15:0] ox, oy, oz;

  afk_pkg::cordic_sts_t csts;
  logic cstart;
  afk_pkg::acc_t acc;
  logic mclr, men;
  logic signed [19:0] ma;
  logic signed [19:0] mb;
  logic signed [19:0] rj [9];
  logic signed [19:0] pj [3];
  logic signed [19:0] nr [9];
  logic signed [19:0] sj, cj;
  logic signed [19:0] la, ld;

  afk_cordic u_cordic (
    .clk(clk), .rst(rst), .start(cstart), .angle(ang[jnt]), .sts(csts)
  );

  afk_mac u_mac (
    .clk(clk), .clr(mclr), .en(men), .a(ma), .b(mb), .acc(acc)
  );

  assign cfg.ready = 1'b1;
  assign in_ch.ready = (state == afk_pkg::ST_IDLE) && !out_valid;
  assign out_ch.valid = out_valid;
  assign out_ch.pos_x = ox;
  assign out_ch.pos_y = oy;
  assign out_ch.pos_z = oz;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_arm <= 14'd7457;
      forearm   <= 14'd6899;
      elb_near  <= 14'd722;
      elb_far   <= 14'd558;
    end else if (cfg.valid) begin
      case (cfg.index)
        afk_pkg::REG_UPPER_ARM:  upper_arm <= cfg.data;
        afk_pkg::REG_FOREARM:    forearm   <= cfg.data;
        afk_pkg::REG_ELBOW_NEAR: elb_near  <= cfg.data;
        afk_pkg::REG_ELBOW_FAR:  elb_far   <= cfg.data;
        default: ;
      endcase
    end
  end

  // joint transform terms
  always_comb begin
    if (afk_pkg::off90_lut(jnt)) begin
      cj = -sn;
      sj = cs;
    end else begin
      cj = cs;
      sj = sn;
    end
    la = 20'sd0;
    ld = 20'sd0;
    case (jnt)
      3'd2: ld = $signed({6'd0, upper_arm});
      3'd3: la = $signed({6'd0, elb_near});
      3'd4: begin
        la = -$signed({6'd0, elb_far});
        ld = $signed({6'd0, forearm});
      end
      default: ;
    endcase
    rj[0] = cj; rj[1] = -sj; rj[2] = '0; pj[0] = la;
    case (afk_pkg::twist_lut(jnt))
      2'd0: begin
        rj[3] = sj; rj[4] = cj; rj[5] = '0; pj[1] = '0;
        rj[6] = '0; rj[7] = '0; rj[8] = 20'sd16384; pj[2] = ld;
      end
      2'd1: begin
        rj[3] = '0; rj[4] = '0; rj[5] = -20'sd16384; pj[1] = -ld;
        rj[6] = sj; rj[7] = cj; rj[8] = '0; pj[2] = '0;
      end
      default: begin
        rj[3] = '0; rj[4] = '0; rj[5] = 20'sd16384; pj[1] = ld;
        rj[6] = -sj; rj[7] = -cj; rj[8] = '0; pj[2] = '0;
      end
    endcase
    ma = rm[{2'b00, r_i} * 4'd3 + {2'b00, m_i}];
    if (k_i == 2'd3) begin
      mb = pj[m_i];
    end else begin
      mb = rj[{2'b00, m_i} * 4'd3 + {2'b00, k_i}];
    end
  end

  always_comb begin
    state_next = state;
    cstart = 1'b0;
    mclr = 1'b0;
    men = 1'b0;
    case (state)
      afk_pkg::ST_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          state_next = afk_pkg::ST_NEXT;
        end
      end
      afk_pkg::ST_NEXT: begin
        if (jnt == count) begin
          state_next = afk_pkg::ST_DONE;
        end else begin
          cstart = 1'b1;
          state_next = afk_pkg::ST_CORDIC;
        end
      end
      afk_pkg::ST_CORDIC: begin
        mclr = 1'b1;
        if (csts.done) begin
          state_next = afk_pkg::ST_MAC;
        end
      end
      afk_pkg::ST_MAC: begin
        men = 1'b1;
        if (m_i == 2'd2) begin
          state_next = afk_pkg::ST_STORE;
        end
      end
      afk_pkg::ST_STORE: begin
        mclr = 1'b1;
        if (r_i == 2'd2 && k_i == 2'd3) begin
          state_next = afk_pkg::ST_NEXT;
        end else begin
          state_next = afk_pkg::ST_MAC;
        end
      end
      afk_pkg::ST_DONE: begin
        state_next = afk_pkg::ST_IDLE;
      end
      default: state_next = afk_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= afk_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      jnt <= '0;
      count <= '0;
      r_i <= '0;
      k_i <= '0;
      m_i <= '0;
    end else begin
      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        afk_pkg::ST_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            ang[0] <= in_ch.joint_angle_0;
            ang[1] <= in_ch.joint_angle_1;
            ang[2] <= in_ch.joint_angle_2;
            ang[3] <= in_ch.joint_angle_3;
            ang[4] <= in_ch.joint_angle_4;
            ang[5] <= in_ch.joint_angle_5;
            count <= (in_ch.joint_count > 3'(afk_pkg::NumJoints)) ?
                     3'(afk_pkg::NumJoints) : in_ch.joint_count;
            jnt <= '0;
            for (int i = 0; i < 9; i++) begin
              rm[i] <= (i % 4 == 0) ? 20'sd16384 : 20'sd0;
            end
            for (int i = 0; i < 3; i++) begin
              pv[i] <= '0;
            end
          end
        end
        afk_pkg::ST_NEXT: begin
          r_i <= '0;
          k_i <= '0;
          m_i <= '0;
        end
        afk_pkg::ST_CORDIC: begin
          if (csts.done) begin
            sn <= csts.sin_v;
            cs <= csts.cos_v;
          end
        end
        afk_pkg::ST_MAC: begin
          m_i <= m_i + 2'd1;
        end
        afk_pkg::ST_STORE: begin
          m_i <= '0;
          if (k_i == 2'd3) begin
            pv[r_i] <= pv[r_i] + 40'(afk_pkg::round_q14(acc));
            k_i <= '0;
            if (r_i == 2'd2) begin
              for (int i = 0; i < 9; i++) begin
                rm[i] <= nr[i];
              end
              jnt <= jnt + 3'd1;
            end else begin
              r_i <= r_i + 2'd1;
            end
          end else begin
            nr[{2'b00, r_i} * 4'd3 + {2'b00, k_i}] <= 20'(afk_pkg::round_q14(acc));
            k_i <= k_i + 2'd1;
          end
        end
        afk_pkg::ST_DONE: begin
          out_valid <= 1'b1;
          ox <= (pv[0] > 40'sd32767) ? 16'sh7fff :
                (pv[0] < -40'sd32768) ? 16'sh8000 : pv[0][15:0];
          oy <= (pv[1] > 40'sd32767) ? 16'sh7fff :
                (pv[1] < -40'sd32768) ? 16'sh8000 : pv[1][15:0];
          oz <= (pv[2] > 40'sd32767) ? 16'sh7fff :
                (pv[2] < -40'sd32768) ? 16'sh8000 : pv[2][15:0];
        end
        default: ;
      endcase
    end
  end
endmodule

// File: hdl/afk_cordic.sv
// Iterative CORDIC sine/cosine unit, one micro-rotation per cycle.
module afk_cordic (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [15:0]   angle,
  output afk_pkg::cordic_sts_t sts
);
  logic signed [19:0] x, y;
  logic signed [19:0] a;
  logic [3:0]         step;
  logic               flip;
  logic               busy;
  logic               done;
  logic signed [19:0] a0;
  logic signed [19:0] sx, sy;

  always_comb begin
    a0 = {{1{angle[15]}}, angle, 3'b000};
    sx = x >>> step;
    sy = y >>> step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        x    <= 20'(afk_pkg::CordicX0);
        y    <= '0;
        if (a0 > 20'sd102944) begin
          a    <= a0 - 20'sd205887;
          flip <= 1'b1;
        end else if (a0 < -20'sd102944) begin
          a    <= a0 + 20'sd205887;
          flip <= 1'b1;
        end else begin
          a    <= a0;
          flip <= 1'b0;
        end
      end else if (busy) begin
        if (step == 4'(afk_pkg::CordicSteps)) begin
          busy <= 1'b0;
          done <= 1'b1;
          if (flip) begin
            x <= -x;
            y <= -y;
          end
        end else begin
          if (a >= 0) begin
            x <= x - sy;
            y <= y + sx;
            a <= a - $signed({2'b00, afk_pkg::atan_lut(step)});
          end else begin
            x <= x + sy;
            y <= y - sx;
            a <= a + $signed({2'b00, afk_pkg::atan_lut(step)});
          end
          step <= step + 4'd1;
        end
      end
    end
  end

  assign sts.busy  = busy;
  assign sts.done  = done;
  assign sts.sin_v = y;
  assign sts.cos_v = x;
endmodule

// File: hdl/afk_mac.sv
// Shared multiply-accumulate unit for the matrix products.
module afk_mac (
  input  logic               clk,
  input  logic               clr,
  input  logic               en,
  input  logic signed [19:0] a,
  input  logic signed [19:0] b,
  output afk_pkg::acc_t      acc
);
  logic signed [39:0] prod;

  always_ff @(posedge clk) begin
    if (clr) begin
      acc <= '0;
    end else if (en) begin
      acc <= acc + {{8{prod[39]}}, prod};
    end
  end

  always_comb begin
    prod = a * b;
  end
endmodule

// File: tb/arm_forward_kinematics_core_tb.sv
// Testbench: random and directed pose transactions checked against a fixed-point predictor.
`timescale 1ns / 100ps
module arm_forward_kinematics_core_tb;

  typedef struct packed {
    logic signed [15:0] a0, a1, a2, a3, a4, a5;
    logic [2:0] cnt;
  } pose_t;

  typedef struct packed {
    logic signed [15:0] x, y, z;
  } posn_t;

  logic clk = 0;
  logic rst = 1;

  afk_in_if  in_ch (clk);
  afk_out_if out_ch (clk);
  afk_cfg_if cfg (clk);

  arm_forward_kinematics_core dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg(cfg.sink)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  longint link_len[4];
  pose_t pose_q[$];
  posn_t posn_q[$];
  int errors = 0;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  bit pause_feed = 0;
  int quiet_cycles = 0;
  localparam int WatchdogLimit = 20000;

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd14(longint v);
    if (v >= 0) return (v + 8192) >>> 14;
    return -((-v + 8192) >>> 14);
  endfunction

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic void joint_sincos(input logic signed [15:0] ang, output longint s,
                                       output longint c);
    longint a, x, y, nx;
    bit flip;
    a = longint'(ang) * 8;
    x = 9949;
    y = 0;
    flip = 0;
    if (a > 102944) begin
      a -= 205887; flip = 1;
    end else if (a < -102944) begin
      a += 205887; flip = 1;
    end
    for (int i = 0; i < 14; i++) begin
      if (a >= 0) begin
        nx = x - fshift(y, i); y = y + fshift(x, i);
        a -= longint'(afk_pkg::atan_lut(4'(i)));
      end else begin
        nx = x + fshift(y, i); y = y - fshift(x, i);
        a += longint'(afk_pkg::atan_lut(4'(i)));
      end
      x = nx;
    end
    if (flip) begin
      x = -x; y = -y;
    end
    s = y;
    c = x;
  endfunction

  function automatic posn_t end_position(pose_t p);
    longint rot[3][3], tr[3], rj[3][3], pj[3], nr[3][3], np[3];
    longint la[6], ld[6], s, c, t, acc, sum;
    logic signed [15:0] ang[6];
    int cnt;
    posn_t res;
    ang = '{p.a0, p.a1, p.a2, p.a3, p.a4, p.a5};
    la = '{0, 0, 0, link_len[afk_pkg::REG_ELBOW_NEAR], -link_len[afk_pkg::REG_ELBOW_FAR], 0};
    ld = '{0, 0, link_len[afk_pkg::REG_UPPER_ARM], 0, link_len[afk_pkg::REG_FOREARM], 0};
    for (int r = 0; r < 3; r++) begin
      tr[r] = 0;
      for (int k = 0; k < 3; k++) rot[r][k] = (r == k) ? 16384 : 0;
    end
    cnt = (p.cnt > 6) ? 6 : p.cnt;
    for (int j = 0; j < cnt; j++) begin
      joint_sincos(ang[j], s, c);
      if (afk_pkg::off90_lut(3'(j))) begin
        t = c; c = -s; s = t;
      end
      rj[0] = '{c, -s, 0};
      pj[0] = la[j];
      case (afk_pkg::twist_lut(3'(j)))
        2'd0: begin
          rj[1] = '{s, c, 0}; pj[1] = 0;
          rj[2] = '{0, 0, 16384}; pj[2] = ld[j];
        end
        2'd1: begin
          rj[1] = '{0, 0, -16384}; pj[1] = -ld[j];
          rj[2] = '{s, c, 0}; pj[2] = 0;
        end
        default: begin
          rj[1] = '{0, 0, 16384}; pj[1] = ld[j];
          rj[2] = '{-s, -c, 0}; pj[2] = 0;
        end
      endcase
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          sum = 0;
          for (int m = 0; m < 3; m++) sum += rot[r][m] * rj[m][k];
          nr[r][k] = rnd14(sum);
        end
        acc = 0;
        for (int m = 0; m < 3; m++) acc += rot[r][m] * pj[m];
        np[r] = rnd14(acc) + tr[r];
      end
      rot = nr;
      tr = np;
    end
    res.x = 16'(clamp16(tr[0]));
    res.y = 16'(clamp16(tr[1]));
    res.z = 16'(clamp16(tr[2]));
    return res;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pose_q.size() && !pause_feed && $urandom_range(99) >= in_idle_pct) begin
        {in_ch.joint_angle_0, in_ch.joint_angle_1, in_ch.joint_angle_2, in_ch.joint_angle_3,
         in_ch.joint_angle_4, in_ch.joint_angle_5, in_ch.joint_count} <= pose_q[0];
        posn_q.push_back(end_position(pose_q.pop_front()));
        in_ch.valid <= 1;
      end else begin
        in_ch.valid <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    posn_t w;
    if (rst) begin
      out_ch.ready <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (posn_q.size() == 0) begin
          report("unexpected transaction", 0, 0);
        end else begin
          w = posn_q.pop_front();
          if (out_ch.pos_x !== w.x) report("pos_x", out_ch.pos_x, w.x);
          if (out_ch.pos_y !== w.y) report("pos_y", out_ch.pos_y, w.y);
          if (out_ch.pos_z !== w.z) report("pos_z", out_ch.pos_z, w.z);
        end
      end
      out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg.valid && cfg.ready) || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(9))
      0: return 16'sd25736;
      1: return -16'sd25736;
      2: return 16'($urandom_range(65535));
      default: return $signed(16'($urandom_range(51472))) - 16'sd25736;
    endcase
  endfunction

  function automatic pose_t rand_pose();
    pose_t p;
    p = '{rand_angle(), rand_angle(), rand_angle(), rand_angle(), rand_angle(),
          rand_angle(), 3'($urandom_range(7))};
    if ($urandom_range(3) != 0) p.cnt = 6;
    return p;
  endfunction

  task automatic drain();
    while (pose_q.size() || posn_q.size() || in_ch.valid) @(posedge clk);
    repeat (450) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [13:0] val);
    cfg.index <= idx;
    cfg.data <= val;
    cfg.valid <= 1;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    link_len[idx] = val;
  endtask

  initial begin
    logic [13:0] lens[4];
    link_len = '{7457, 6899, 722, 558};
    cfg.valid = 0;
    cfg.index = afk_pkg::REG_UPPER_ARM;
    cfg.data = 0;
    in_ch.valid = 0;
    {in_ch.joint_angle_0, in_ch.joint_angle_1, in_ch.joint_angle_2, in_ch.joint_angle_3,
     in_ch.joint_angle_4, in_ch.joint_angle_5, in_ch.joint_count} = '0;
    out_ch.ready = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // defaults: zero joints, each count, extremes, folding edges, out-of-range angles
    for (int n = 0; n < 8; n++) pose_q.push_back('{0, 0, 0, 0, 0, 0, 3'(n)});
    pose_q.push_back('{16'sd25736, 16'sd25736, 16'sd25736, 16'sd25736, 16'sd25736,
                       16'sd25736, 3'd6});
    pose_q.push_back('{-16'sd25736, -16'sd25736, -16'sd25736, -16'sd25736, -16'sd25736,
                       -16'sd25736, 3'd6});
    pose_q.push_back('{16'sd12868, -16'sd12868, 16'sd12869, -16'sd12869, 16'sd12868,
                       -16'sd12869, 3'd6});
    pose_q.push_back('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 3'd6});
    pose_q.push_back('{16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555, 16'sh5555, 16'shaaaa, 3'd7});
    drain();
    // the extremes of the link registers, then random settings
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: lens = '{14'h3fff, 14'h3fff, 14'h3fff, 14'h3fff};
        1: lens = '{0, 0, 0, 0};
        default: lens = '{14'($urandom), 14'($urandom), 14'($urandom), 14'($urandom)};
      endcase
      for (int r = 0; r < 4; r++) write_reg(2'(r), lens[r]);
      cfg.valid <= 0;
      if (phase < 2) begin
        pose_q.push_back('{16'sd25736, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 3'd6});
        pose_q.push_back('{16'sd0, 16'sd25736, -16'sd25736, 16'sd0, 16'sd0, 16'sd0, 3'd6});
        pose_q.push_back(rand_pose());
        drain();
      end else begin
        in_idle_pct = (phase == 2) ? 33 : (phase == 3) ? 52 : 0;
        out_idle_pct = (phase == 2) ? 52 : (phase == 3) ? 33 : 0;
        for (int i = 0; i < 300; i++) pose_q.push_back(rand_pose());
        if (phase == 4) begin
          while (pose_q.size() > 150) @(posedge clk);
          pause_feed = 1;
          while (posn_q.size()) @(posedge clk);
          pause_feed = 0;
        end
        drain();
      end
    end
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
